FILE: sv/rsh_pkg.sv
package rsh_pkg;

	localparam int SQ_STAGES = 16;
	localparam int DV_STAGES = 16;
	localparam int NCOEF     = 16;

	localparam logic [31:0] ONE_Q30 = 32'h4000_0000;
	localparam logic [1:0]  DEG_RESET = 2'd3;

	localparam logic signed [19:0] COEF_MAX = 20'sd524287;
	localparam logic signed [19:0] COEF_MIN = -20'sd524288;
	localparam logic signed [19:0] Y00      = 20'sd18487;

	typedef logic signed [31:0] q30_t;
	typedef logic signed [33:0] poly_t;
	typedef logic signed [19:0] coef_t;
	typedef coef_t [NCOEF-1:0] coef_vec_t;
	typedef logic [3:0] cidx_t;

	typedef struct packed {
		logic [2:0] neg;
		logic       zero;
	} side_t;

	typedef struct packed {
		logic [33:0] rem;
		logic [31:0] root;
	} sq_t;

	typedef struct packed {
		logic [31:0] rem;
		logic [31:0] quo;
	} dv_t;

	// Normalization constants in Q.28, indexed in band order.
	function automatic q30_t kfac(input cidx_t idx);
		q30_t k;
		unique case (idx)
			4'd0:                   k = 32'sd75724244;
			4'd1, 4'd2, 4'd3:       k = 32'sd131158238;
			4'd4, 4'd5, 4'd7:       k = 32'sd293278736;
			4'd6:                   k = 32'sd84662279;
			4'd8:                   k = 32'sd146639368;
			4'd9, 4'd15:            k = 32'sd158388620;
			4'd10:                  k = 32'sd775942601;
			4'd11, 4'd13:           k = 32'sd122687298;
			4'd12:                  k = 32'sd100173759;
			4'd14:                  k = 32'sd387971300;
			default:                k = 32'sd0;
		endcase
		return k;
	endfunction

	function automatic poly_t sx34(input q30_t v);
		return {{2{v[31]}}, v};
	endfunction

	function automatic sq_t sqrt_step(input sq_t s, input logic [1:0] pair);
		logic [35:0] acc;
		logic [35:0] trial;
		sq_t o;
		acc = {s.rem, pair};
		trial = {2'b00, s.root, 2'b01};
		if (acc >= trial) begin
			acc = acc - trial;
			o.root = {s.root[30:0], 1'b1};
		end else begin
			o.root = {s.root[30:0], 1'b0};
		end
		o.rem = acc[33:0];
		return o;
	endfunction

	function automatic sq_t sqrt_step2(input sq_t s, input logic [3:0] bits);
		return sqrt_step(sqrt_step(s, bits[3:2]), bits[1:0]);
	endfunction

	function automatic dv_t dv_step(input dv_t s, input logic b, input logic [31:0] d);
		logic [32:0] acc;
		dv_t o;
		acc = {s.rem, b};
		if (acc >= {1'b0, d}) begin
			acc = acc - {1'b0, d};
			o.quo = {s.quo[30:0], 1'b1};
		end else begin
			o.quo = {s.quo[30:0], 1'b0};
		end
		o.rem = acc[31:0];
		return o;
	endfunction

	function automatic dv_t dv_step2(input dv_t s, input logic [1:0] bits,
		input logic [31:0] d);
		return dv_step(dv_step(s, bits[1], d), bits[0], d);
	endfunction

endpackage

FILE: sv/rsh_if.sv
interface rsh_vec_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] vec_x;
	logic signed [31:0] vec_y;
	logic signed [31:0] vec_z;
	modport source(output valid, output vec_x, output vec_y, output vec_z, input ready);
	modport sink(input valid, input vec_x, input vec_y, input vec_z, output ready);
endinterface

interface rsh_band_if;
	logic               valid;
	logic               ready;
	logic [1:0]         degree;
	logic signed [19:0] coef_0;
	logic signed [19:0] coef_1;
	logic signed [19:0] coef_2;
	logic signed [19:0] coef_3;
	logic signed [19:0] coef_4;
	logic signed [19:0] coef_5;
	logic signed [19:0] coef_6;
	logic               last_band;
	modport source(output valid, output degree, output coef_0, output coef_1,
		output coef_2, output coef_3, output coef_4, output coef_5, output coef_6,
		output last_band, input ready);
	modport sink(input valid, input degree, input coef_0, input coef_1,
		input coef_2, input coef_3, input coef_4, input coef_5, input coef_6,
		input last_band, output ready);
endinterface

interface rsh_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] max_degree;
	modport source(output valid, output max_degree, input ready);
	modport sink(input valid, input max_degree, output ready);
endinterface

FILE: sv/rsh_mul.sv
module rsh_mul #(
	parameter int AW = 32,
	parameter int BW = 32,
	parameter int SH = 30,
	parameter int OW = 32
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [AW-1:0] a,
	input  logic signed [BW-1:0] b,
	output logic signed [OW-1:0] p
);

	logic [AW-1:0]    ma;
	logic [BW-1:0]    mb;
	logic [AW+BW-1:0] prod_s1;
	logic             neg_s1;
	logic [AW+BW:0]   rnd;
	logic [OW-1:0]    mag;
	logic signed [OW-1:0] p_s2;

	assign ma  = a[AW-1] ? (~a + 1'b1) : a;
	assign mb  = b[BW-1] ? (~b + 1'b1) : b;
	assign rnd = {1'b0, prod_s1} + ((AW+BW+1)'(1) << (SH-1));
	assign mag = OW'(rnd >> SH);
	assign p   = p_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= ma * mb;
			neg_s1  <= a[AW-1] ^ b[BW-1];
			p_s2    <= neg_s1 ? -$signed(mag) : $signed(mag);
		end
	end

endmodule

FILE: sv/rsh_norm.sv
module rsh_norm (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic signed [31:0] vec_x,
	input  logic signed [31:0] vec_y,
	input  logic signed [31:0] vec_z,
	output logic               u_valid,
	output rsh_pkg::q30_t      u_x,
	output rsh_pkg::q30_t      u_y,
	output rsh_pkg::q30_t      u_z
);

	localparam int SQN = rsh_pkg::SQ_STAGES;
	localparam int DVN = rsh_pkg::DV_STAGES;

	logic [31:0] raw [3];
	logic [31:0] mag [3];
	logic [31:0] big;
	logic [4:0]  top_pos;
	logic [4:0]  sh;
	logic [31:0] qc [3];
	rsh_pkg::q30_t un [3];

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s23, v_s40;
	logic [31:0] a_s1 [3];
	logic [31:0] a_s2 [3];
	logic [31:0] a_s3 [3];
	logic [31:0] a_s4 [3];
	logic [31:0] a_s5 [3];
	logic [31:0] a_s6 [3];
	logic [2:0]  neg_s1, neg_s2;
	logic [31:0] big_s2;
	logic [4:0]  sh_s3;
	rsh_pkg::side_t side_s3, side_s4, side_s5, side_s6, side_s23;
	logic [63:0] sqr_s5 [3];
	logic [63:0] r2_s6;

	rsh_pkg::sq_t   sq_s [SQN];
	logic [63:0]    sq_r2_s [SQN];
	logic [31:0]    sq_a_s [SQN][3];
	rsh_pkg::side_t sq_side_s [SQN];
	logic [SQN-1:0] sq_v_s;

	logic [61:0] num_s23 [3];
	logic [31:0] den_s23;

	rsh_pkg::dv_t   dv_s [DVN][3];
	logic [31:0]    dv_n_s [DVN][3];
	logic [31:0]    dv_d_s [DVN];
	rsh_pkg::side_t dv_side_s [DVN];
	logic [DVN-1:0] dv_v_s;

	rsh_pkg::q30_t u_s40 [3];

	always_comb begin
		raw[0] = vec_x;
		raw[1] = vec_y;
		raw[2] = vec_z;
		for (int i = 0; i < 3; i++) begin
			mag[i] = raw[i][31] ? (~raw[i] + 32'd1) : raw[i];
		end
		big = a_s1[0];
		if (a_s1[1] > big) begin
			big = a_s1[1];
		end
		if (a_s1[2] > big) begin
			big = a_s1[2];
		end
		top_pos = '0;
		for (int i = 0; i < 32; i++) begin
			if (big_s2[i]) begin
				top_pos = 5'(i);
			end
		end
		sh = (top_pos >= 5'd30) ? 5'd0 : 5'd30 - top_pos;
		for (int i = 0; i < 3; i++) begin
			qc[i] = dv_s[DVN-1][i].quo;
			if (qc[i] > rsh_pkg::ONE_Q30) begin
				qc[i] = rsh_pkg::ONE_Q30;
			end
			if (dv_side_s[DVN-1].zero) begin
				qc[i] = '0;
			end
			un[i] = dv_side_s[DVN-1].neg[i] ? -$signed(qc[i]) : $signed(qc[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			v_s5   <= 1'b0;
			v_s6   <= 1'b0;
			sq_v_s <= '0;
			v_s23  <= 1'b0;
			dv_v_s <= '0;
			v_s40  <= 1'b0;
		end else if (en) begin
			v_s1   <= in_valid;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
			v_s5   <= v_s4;
			v_s6   <= v_s5;
			sq_v_s <= {sq_v_s[SQN-2:0], v_s6};
			v_s23  <= sq_v_s[SQN-1];
			dv_v_s <= {dv_v_s[DVN-2:0], v_s23};
			v_s40  <= dv_v_s[DVN-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				a_s1[i]   <= mag[i];
				a_s2[i]   <= a_s1[i];
				a_s3[i]   <= a_s2[i];
				a_s4[i]   <= a_s3[i] << sh_s3;
				sqr_s5[i] <= 64'(a_s4[i]) * 64'(a_s4[i]);
				a_s5[i]   <= a_s4[i];
				a_s6[i]   <= a_s5[i];
			end
			neg_s1  <= {raw[2][31], raw[1][31], raw[0][31]};
			neg_s2  <= neg_s1;
			big_s2  <= big;
			sh_s3   <= sh;
			side_s3 <= '{neg: neg_s2, zero: (big_s2 == '0)};
			side_s4 <= side_s3;
			side_s5 <= side_s4;
			side_s6 <= side_s5;
			r2_s6   <= sqr_s5[0] + sqr_s5[1] + sqr_s5[2];

			sq_s[0]      <= rsh_pkg::sqrt_step2('0, r2_s6[63:60]);
			sq_r2_s[0]   <= r2_s6;
			sq_a_s[0]    <= a_s6;
			sq_side_s[0] <= side_s6;
			for (int k = 1; k < SQN; k++) begin
				sq_s[k]      <= rsh_pkg::sqrt_step2(sq_s[k-1], sq_r2_s[k-1][63-4*k -: 4]);
				sq_r2_s[k]   <= sq_r2_s[k-1];
				sq_a_s[k]    <= sq_a_s[k-1];
				sq_side_s[k] <= sq_side_s[k-1];
			end

			den_s23  <= sq_s[SQN-1].root;
			side_s23 <= sq_side_s[SQN-1];
			for (int i = 0; i < 3; i++) begin
				num_s23[i] <= {sq_a_s[SQN-1][i], 30'b0} + 62'(sq_s[SQN-1].root >> 1);
			end

			for (int i = 0; i < 3; i++) begin
				dv_s[0][i]   <= rsh_pkg::dv_step2('{rem: {2'b00, num_s23[i][61:32]}, quo: '0},
					num_s23[i][31:30], den_s23);
				dv_n_s[0][i] <= num_s23[i][31:0];
			end
			dv_d_s[0]    <= den_s23;
			dv_side_s[0] <= side_s23;
			for (int k = 1; k < DVN; k++) begin
				for (int i = 0; i < 3; i++) begin
					dv_s[k][i]   <= rsh_pkg::dv_step2(dv_s[k-1][i],
						dv_n_s[k-1][i][31-2*k -: 2], dv_d_s[k-1]);
					dv_n_s[k][i] <= dv_n_s[k-1][i];
				end
				dv_d_s[k]    <= dv_d_s[k-1];
				dv_side_s[k] <= dv_side_s[k-1];
			end

			for (int i = 0; i < 3; i++) begin
				u_s40[i] <= un[i];
			end
		end
	end

	assign u_valid = v_s40;
	assign u_x     = u_s40[0];
	assign u_y     = u_s40[1];
	assign u_z     = u_s40[2];

endmodule

FILE: sv/rsh_poly.sv
module rsh_poly (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  rsh_pkg::q30_t      u_x,
	input  rsh_pkg::q30_t      u_y,
	input  rsh_pkg::q30_t      u_z,
	output logic               out_valid,
	output rsh_pkg::coef_vec_t coef
);

	localparam int NC = rsh_pkg::NCOEF;

	logic [7:0] pv_s;

	rsh_pkg::q30_t xyz_s [5][3];
	rsh_pkg::q30_t xx, yy, zz, xy, yz, xz;
	rsh_pkg::poly_t c3a_s3, c4_s3, c2b_s3, c3b_s3;
	rsh_pkg::poly_t l2_s3 [5];
	rsh_pkg::poly_t l2_s4 [5];
	rsh_pkg::poly_t l2_s5 [5];
	rsh_pkg::poly_t m2 [9:NC-1];
	rsh_pkg::poly_t pv [1:NC-1];
	logic signed [23:0] kp [1:NC-1];
	rsh_pkg::coef_vec_t coef_s8;

	rsh_pkg::poly_t wxx, wyy, wzz;

	rsh_mul #(.AW(32), .BW(32), .SH(30), .OW(32)) u_mxx (
		.clk(clk), .en(en), .a(u_x), .b(u_x), .p(xx));
	rsh_mul #(.AW(32), .BW(32), .SH(30), .OW(32)) u_myy (
		.clk(clk), .en(en), .a(u_y), .b(u_y), .p(yy));
	rsh_mul #(.AW(32), .BW(32), .SH(30), .OW(32)) u_mzz (
		.clk(clk), .en(en), .a(u_z), .b(u_z), .p(zz));
	rsh_mul #(.AW(32), .BW(32), .SH(30), .OW(32)) u_mxy (
		.clk(clk), .en(en), .a(u_x), .b(u_y), .p(xy));
	rsh_mul #(.AW(32), .BW(32), .SH(30), .OW(32)) u_myz (
		.clk(clk), .en(en), .a(u_y), .b(u_z), .p(yz));
	rsh_mul #(.AW(32), .BW(32), .SH(30), .OW(32)) u_mxz (
		.clk(clk), .en(en), .a(u_x), .b(u_z), .p(xz));

	always_comb begin
		wxx = rsh_pkg::sx34(xx);
		wyy = rsh_pkg::sx34(yy);
		wzz = rsh_pkg::sx34(zz);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_s <= '0;
		end else if (en) begin
			pv_s <= {pv_s[6:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xyz_s[0][0] <= u_x;
			xyz_s[0][1] <= u_y;
			xyz_s[0][2] <= u_z;
			for (int k = 1; k < 5; k++) begin
				xyz_s[k] <= xyz_s[k-1];
			end
			c3a_s3   <= 3 * wxx - wyy;
			c4_s3    <= 4 * wzz - wxx - wyy;
			c2b_s3   <= 2 * wzz - 3 * wxx - 3 * wyy;
			c3b_s3   <= wxx - 3 * wyy;
			l2_s3[0] <= rsh_pkg::sx34(xy);
			l2_s3[1] <= rsh_pkg::sx34(yz);
			l2_s3[2] <= 2 * wzz - wxx - wyy;
			l2_s3[3] <= rsh_pkg::sx34(xz);
			l2_s3[4] <= wxx - wyy;
			l2_s4    <= l2_s3;
			l2_s5    <= l2_s4;
		end
	end

	rsh_mul #(.AW(32), .BW(34), .SH(30), .OW(34)) u_m9 (
		.clk(clk), .en(en), .a(xyz_s[2][1]), .b(c3a_s3), .p(m2[9]));
	rsh_mul #(.AW(32), .BW(34), .SH(30), .OW(34)) u_m10 (
		.clk(clk), .en(en), .a(l2_s3[0][31:0]), .b(rsh_pkg::sx34(xyz_s[2][2])), .p(m2[10]));
	rsh_mul #(.AW(32), .BW(34), .SH(30), .OW(34)) u_m11 (
		.clk(clk), .en(en), .a(xyz_s[2][1]), .b(c4_s3), .p(m2[11]));
	rsh_mul #(.AW(32), .BW(34), .SH(30), .OW(34)) u_m12 (
		.clk(clk), .en(en), .a(xyz_s[2][2]), .b(c2b_s3), .p(m2[12]));
	rsh_mul #(.AW(32), .BW(34), .SH(30), .OW(34)) u_m13 (
		.clk(clk), .en(en), .a(xyz_s[2][0]), .b(c4_s3), .p(m2[13]));
	rsh_mul #(.AW(32), .BW(34), .SH(30), .OW(34)) u_m14 (
		.clk(clk), .en(en), .a(xyz_s[2][2]), .b(l2_s3[4]), .p(m2[14]));
	rsh_mul #(.AW(32), .BW(34), .SH(30), .OW(34)) u_m15 (
		.clk(clk), .en(en), .a(xyz_s[2][0]), .b(c3b_s3), .p(m2[15]));

	always_comb begin
		pv[1] = rsh_pkg::sx34(xyz_s[4][1]);
		pv[2] = rsh_pkg::sx34(xyz_s[4][2]);
		pv[3] = rsh_pkg::sx34(xyz_s[4][0]);
		for (int j = 0; j < 5; j++) begin
			pv[4+j] = l2_s5[j];
		end
		for (int j = 9; j < NC; j++) begin
			pv[j] = m2[j];
		end
	end

	for (genvar j = 1; j < NC; j++) begin : g_scale
		rsh_mul #(.AW(32), .BW(34), .SH(42), .OW(24)) u_mk (
			.clk(clk), .en(en), .a(rsh_pkg::kfac(rsh_pkg::cidx_t'(j))), .b(pv[j]),
			.p(kp[j]));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			coef_s8[0] <= rsh_pkg::Y00;
			for (int j = 1; j < NC; j++) begin
				if (kp[j] > rsh_pkg::COEF_MAX) begin
					coef_s8[j] <= rsh_pkg::COEF_MAX;
				end else if (kp[j] < rsh_pkg::COEF_MIN) begin
					coef_s8[j] <= rsh_pkg::COEF_MIN;
				end else begin
					coef_s8[j] <= kp[j][19:0];
				end
			end
		end
	end

	assign out_valid = pv_s[7];
	assign coef      = coef_s8;

endmodule

FILE: sv/rsh_band.sv
module rsh_band (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  rsh_pkg::coef_vec_t coef,
	input  logic [1:0]         lmax,
	output logic               adv,
	rsh_band_if.source         out
);

	logic               hold_v_q;
	logic [1:0]         band_q;
	rsh_pkg::coef_vec_t coef_q;
	logic               last;
	logic               take;

	assign last = (band_q == lmax);
	assign take = !hold_v_q || (out.ready && last);
	assign adv  = take || !in_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q <= 1'b0;
			band_q   <= '0;
		end else if (take) begin
			hold_v_q <= in_valid;
			band_q   <= '0;
		end else if (out.ready) begin
			band_q <= band_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (take && in_valid) begin
			coef_q <= coef;
		end
	end

	always_comb begin
		out.valid     = hold_v_q;
		out.degree    = band_q;
		out.last_band = last;
		out.coef_0    = '0;
		out.coef_1    = '0;
		out.coef_2    = '0;
		out.coef_3    = '0;
		out.coef_4    = '0;
		out.coef_5    = '0;
		out.coef_6    = '0;
		unique case (band_q)
			2'd0: begin
				out.coef_0 = coef_q[0];
			end
			2'd1: begin
				out.coef_0 = coef_q[1];
				out.coef_1 = coef_q[2];
				out.coef_2 = coef_q[3];
			end
			2'd2: begin
				out.coef_0 = coef_q[4];
				out.coef_1 = coef_q[5];
				out.coef_2 = coef_q[6];
				out.coef_3 = coef_q[7];
				out.coef_4 = coef_q[8];
			end
			2'd3: begin
				out.coef_0 = coef_q[9];
				out.coef_1 = coef_q[10];
				out.coef_2 = coef_q[11];
				out.coef_3 = coef_q[12];
				out.coef_4 = coef_q[13];
				out.coef_5 = coef_q[14];
				out.coef_6 = coef_q[15];
			end
			default: begin
				out.coef_0 = '0;
			end
		endcase
	end

`ifndef ASSERT_OFF
	a_band_range: assert property (@(posedge clk) disable iff (!arst_n)
		hold_v_q |-> band_q <= lmax)
		else $error("band index beyond the highest degree");

	a_band_next: assert property (@(posedge clk) disable iff (!arst_n)
		(out.valid && out.ready && !out.last_band) |=>
		(out.valid && out.degree == $past(out.degree) + 2'd1))
		else $error("bands of one vector are not consecutive");

	a_band_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(out.valid && out.ready && out.last_band) |=> (!out.valid || out.degree == 2'd0))
		else $error("a new vector does not start at degree zero");
`endif

endmodule

FILE: sv/real_spherical_harmonics.sv
// Channel   Role     Transaction
// vec_in    sink     one edge vector: vec_x, vec_y, vec_z in signed Q16.16
// band_out  source   one degree band: degree, coef_0..coef_6 in Q3.16, last_band
// cfg       sink     max_degree write, always ready
//
// A vector passes through rsh_norm and rsh_poly into the band output register.
// A band_out stall holds both pipelines only while a vector waits to enter it.
// The square root and the three divisions each take sixteen pipeline stages.
// The output port emits one band per cycle while band_out is ready; a vector
// occupies lmax + 1 bands (max_degree capped at MAX_DEGREE); the next vector is
// loaded as its last band is taken. Reset clears valid bits and the band index.
module real_spherical_harmonics #(
	parameter int MAX_DEGREE = 3
) (
	input  logic       clk,
	input  logic       arst_n,
	rsh_vec_if.sink    vec_in,
	rsh_band_if.source band_out,
	rsh_cfg_if.sink    cfg
);

	logic [1:0]         max_degree_q;
	logic [1:0]         lmax;
	logic               adv;
	logic               u_valid;
	rsh_pkg::q30_t      u_x, u_y, u_z;
	logic               c_valid;
	rsh_pkg::coef_vec_t coef;

	assign cfg.ready    = 1'b1;
	assign vec_in.ready = adv;
	assign lmax = (max_degree_q > 2'(MAX_DEGREE)) ? 2'(MAX_DEGREE) : max_degree_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_degree_q <= rsh_pkg::DEG_RESET;
		end else if (cfg.valid) begin
			max_degree_q <= cfg.max_degree;
		end
	end

	rsh_norm u_norm (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_valid(vec_in.valid),
		.vec_x(vec_in.vec_x), .vec_y(vec_in.vec_y), .vec_z(vec_in.vec_z),
		.u_valid(u_valid), .u_x(u_x), .u_y(u_y), .u_z(u_z));

	rsh_poly u_poly (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_valid(u_valid),
		.u_x(u_x), .u_y(u_y), .u_z(u_z), .out_valid(c_valid), .coef(coef));

	rsh_band u_band (
		.clk(clk), .arst_n(arst_n), .in_valid(c_valid), .coef(coef), .lmax(lmax),
		.adv(adv), .out(band_out));

endmodule
